// ----- sv/vtsm_pkg.sv -----
// Shared types, constants and helper functions of the voxel to sprite-sheet mapper.
`timescale 1ns / 1ps

package vtsm_pkg;

	localparam int PALETTE_ENTRIES_DEF = 256;
	localparam int COORD_BITS          = 8;
	localparam int COLOR_BITS          = 32;
	localparam int DIM_BITS            = 9;
	localparam int SHEET_BITS          = 16;
	localparam int INDEX_BITS          = 32;
	localparam logic [7:0] COLOR_MOD   = 8'hFF;

	typedef struct packed {
		logic [1:0]            req_type;
		logic [COORD_BITS-1:0] vox_x;
		logic [COORD_BITS-1:0] vox_y;
		logic [COORD_BITS-1:0] vox_z;
		logic [7:0]            color_index;
		logic [7:0]            palette_addr;
		logic [COLOR_BITS-1:0] palette_word;
		logic [DIM_BITS-1:0]   model_x_dim;
		logic [DIM_BITS-1:0]   model_y_dim;
	} in_t;

	typedef struct packed {
		logic [SHEET_BITS-1:0] pixel_x;
		logic [SHEET_BITS-1:0] pixel_y;
		logic [INDEX_BITS-1:0] pixel_index;
		logic [COLOR_BITS-1:0] pixel_color;
	} out_t;

	typedef struct packed {
		logic                  layout_mode;
		logic [DIM_BITS-1:0]   cells_per_row;
		logic [DIM_BITS-1:0]   cell_width;
		logic [DIM_BITS-1:0]   cell_height;
		logic [SHEET_BITS-1:0] sheet_width;
	} cfg_t;

	typedef struct packed {
		logic                  done;
		logic [COORD_BITS-1:0] quotient;
		logic [DIM_BITS-1:0]   remainder;
	} div_res_t;

	// Palette entry for a colour index: (index + 254) mod 255.
	function automatic logic [7:0] color_entry(input logic [7:0] ci);
		logic [7:0] e;
		if (ci == 8'd0 || ci == COLOR_MOD) begin
			e = COLOR_MOD - 8'd1;
		end else begin
			e = ci - 8'd1;
		end
		return e;
	endfunction

	function automatic logic [SHEET_BITS-1:0] sat16(input logic [19:0] v);
		logic [SHEET_BITS-1:0] r;
		if (v[19:16] != 4'd0) begin
			r = '1;
		end else begin
			r = v[15:0];
		end
		return r;
	endfunction

endpackage

// ----- sv/vtsm_palette_ram.sv -----
// Palette memory: one write port, one read port with registered read data.
`timescale 1ns / 1ps

module vtsm_palette_ram #(
	parameter int ENTRIES = vtsm_pkg::PALETTE_ENTRIES_DEF,
	parameter int ADDR_W  = $clog2(ENTRIES)
) (
	input  logic                            clk,
	input  logic                            we,
	input  logic [ADDR_W-1:0]               waddr,
	input  logic [vtsm_pkg::COLOR_BITS-1:0] wdata,
	input  logic                            re,
	input  logic [ADDR_W-1:0]               raddr,
	output logic [vtsm_pkg::COLOR_BITS-1:0] rdata
);
	import vtsm_pkg::*;

	logic [COLOR_BITS-1:0] mem_q [ENTRIES];
	logic [COLOR_BITS-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- sv/vtsm_div.sv -----
// Restoring divider for the slice number, four quotient bits per cycle.
`timescale 1ns / 1ps

module vtsm_div (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic [vtsm_pkg::COORD_BITS-1:0] dividend,
	input  logic [vtsm_pkg::DIM_BITS-1:0]   divisor,
	output vtsm_pkg::div_res_t              res
);
	import vtsm_pkg::*;

	localparam int STEPS  = 4;
	localparam int CYCLES = COORD_BITS / STEPS;
	localparam int CNT_W  = $clog2(CYCLES + 1);

	logic [CNT_W-1:0]      cnt_q;
	logic [DIM_BITS-1:0]   rem_q;
	logic [COORD_BITS-1:0] quo_q;
	logic [COORD_BITS-1:0] dvd_q;
	logic [DIM_BITS-1:0]   dvs_q;

	logic [DIM_BITS-1:0]   rem_n;
	logic [COORD_BITS-1:0] quo_n;
	logic [COORD_BITS-1:0] dvd_n;

	always_comb begin
		logic [DIM_BITS:0] t;
		rem_n = rem_q;
		quo_n = quo_q;
		dvd_n = dvd_q;
		for (int i = 0; i < STEPS; i++) begin
			t = {rem_n, dvd_n[COORD_BITS-1]};
			dvd_n = {dvd_n[COORD_BITS-2:0], 1'b0};
			if (t >= {1'b0, dvs_q}) begin
				t = t - {1'b0, dvs_q};
				quo_n = {quo_n[COORD_BITS-2:0], 1'b1};
			end else begin
				quo_n = {quo_n[COORD_BITS-2:0], 1'b0};
			end
			rem_n = t[DIM_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= CNT_W'(CYCLES);
			rem_q <= '0;
			quo_q <= '0;
			dvd_q <= '0;
			dvs_q <= DIM_BITS'(1);
		end else if (start) begin
			cnt_q <= '0;
			rem_q <= '0;
			quo_q <= '0;
			dvd_q <= dividend;
			// A zero cell count behaves as one cell per row.
			dvs_q <= (divisor == '0) ? DIM_BITS'(1) : divisor;
		end else if (cnt_q != CNT_W'(CYCLES)) begin
			cnt_q <= cnt_q + CNT_W'(1);
			rem_q <= rem_n;
			quo_q <= quo_n;
			dvd_q <= dvd_n;
		end
	end

	assign res.done      = (cnt_q == CNT_W'(CYCLES));
	assign res.quotient  = quo_q;
	assign res.remainder = rem_q;

endmodule

// ----- sv/vtsm_cfg.sv -----
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps

module vtsm_cfg (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	output vtsm_pkg::cfg_t cfg
);
	import vtsm_pkg::*;

	localparam logic [2:0] REG_LAYOUT_MODE   = 3'd0;
	localparam logic [2:0] REG_CELLS_PER_ROW = 3'd1;
	localparam logic [2:0] REG_CELL_WIDTH    = 3'd2;
	localparam logic [2:0] REG_CELL_HEIGHT   = 3'd3;
	localparam logic [2:0] REG_SHEET_WIDTH   = 3'd4;

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.layout_mode   <= 1'b0;
			cfg_q.cells_per_row <= DIM_BITS'(1);
			cfg_q.cell_width    <= DIM_BITS'(1);
			cfg_q.cell_height   <= DIM_BITS'(1);
			cfg_q.sheet_width   <= SHEET_BITS'(1);
		end else if (wr_en) begin
			case (reg_idx)
				REG_LAYOUT_MODE:   cfg_q.layout_mode   <= pwdata[0];
				REG_CELLS_PER_ROW: cfg_q.cells_per_row <= pwdata[DIM_BITS-1:0];
				REG_CELL_WIDTH:    cfg_q.cell_width    <= pwdata[DIM_BITS-1:0];
				REG_CELL_HEIGHT:   cfg_q.cell_height   <= pwdata[DIM_BITS-1:0];
				REG_SHEET_WIDTH:   cfg_q.sheet_width   <= pwdata[SHEET_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_LAYOUT_MODE:   prdata = 32'(cfg_q.layout_mode);
			REG_CELLS_PER_ROW: prdata = 32'(cfg_q.cells_per_row);
			REG_CELL_WIDTH:    prdata = 32'(cfg_q.cell_width);
			REG_CELL_HEIGHT:   prdata = 32'(cfg_q.cell_height);
			REG_SHEET_WIDTH:   prdata = 32'(cfg_q.sheet_width);
			default:           prdata = '0;
		endcase
	end

	assign cfg = cfg_q;

endmodule

// ----- sv/voxel_to_sprite_sheet_mapper_unit.sv -----
// Top level of the voxel to sprite-sheet mapper: sequencer, model state and result register.
`timescale 1ns / 1ps

// A voxel beat runs through these states up to the next acceptance: the palette RAM is
// read at the accepting edge, the slice divider resolves four quotient bits in each of the
// S_DIV0 and S_DIV1 states, S_MAP forms the saturated column and row, and S_EMIT forms the
// linear address and loads the result register (this last state repeats while that register
// still holds an untaken result). Palette writes and begin-model beats complete at the edge
// that accepts them, so the next beat may follow in the next cycle. The palette has no reset:
// a voxel that reads an entry never written returns an undefined colour.
module voxel_to_sprite_sheet_mapper_unit #(
	parameter int PALETTE_ENTRIES = vtsm_pkg::PALETTE_ENTRIES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	input  logic               in_valid,
	output logic               in_stall,
	input  vtsm_pkg::in_t      in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output vtsm_pkg::out_t     out_data
);
	import vtsm_pkg::*;

	localparam int AW = $clog2(PALETTE_ENTRIES);

	localparam logic [1:0] REQ_VOXEL       = 2'd0;
	localparam logic [1:0] REQ_PAL_WRITE   = 2'd1;
	localparam logic [1:0] REQ_BEGIN_MODEL = 2'd2;

	typedef enum logic [2:0] {S_IDLE, S_DIV0, S_DIV1, S_MAP, S_EMIT} state_t;

	cfg_t     cfg;
	div_res_t div_res;

	state_t                state_q;
	logic                  out_valid_q;
	out_t                  out_data_q;
	logic [COORD_BITS-1:0] vx_q;
	logic [COORD_BITS-1:0] vy_q;
	logic [COORD_BITS-1:0] vz_q;
	logic [SHEET_BITS-1:0] px_q;
	logic [SHEET_BITS-1:0] py_q;

	logic [SHEET_BITS-1:0] row_base_q;
	logic [DIM_BITS-1:0]   pending_height_q;
	logic [DIM_BITS-1:0]   model_width_q;

	logic                  accept;
	logic                  is_voxel;
	logic                  is_pal_write;
	logic                  is_begin;
	logic                  out_free;
	logic [COLOR_BITS-1:0] pal_rdata;
	logic [7:0]            entry;

	logic [17:0]           grid_x_prod;
	logic [16:0]           grid_y_prod;
	logic [16:0]           anim_x_prod;
	logic [19:0]           px_sum;
	logic [19:0]           py_sum;
	logic [INDEX_BITS-1:0] idx_prod;

	assign accept       = in_valid && !in_stall;
	assign is_voxel     = accept && (in_data.req_type == REQ_VOXEL);
	assign is_pal_write = accept && (in_data.req_type == REQ_PAL_WRITE);
	assign is_begin     = accept && (in_data.req_type == REQ_BEGIN_MODEL);
	assign in_stall     = (state_q != S_IDLE);
	assign out_free     = !out_valid_q || !out_stall;
	assign entry        = color_entry(in_data.color_index);

	vtsm_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	vtsm_palette_ram #(
		.ENTRIES (PALETTE_ENTRIES)
	) u_ram (
		.clk   (clk),
		.we    (is_pal_write),
		.waddr (in_data.palette_addr[AW-1:0]),
		.wdata (in_data.palette_word),
		.re    (is_voxel),
		.raddr (entry[AW-1:0]),
		.rdata (pal_rdata)
	);

	vtsm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (is_voxel),
		.dividend (in_data.vox_z),
		.divisor  (cfg.cells_per_row),
		.res      (div_res)
	);

	// Model state moves at the edge that accepts a begin-model beat.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_base_q       <= '0;
			pending_height_q <= '0;
			model_width_q    <= DIM_BITS'(1);
		end else if (is_begin) begin
			row_base_q       <= sat16(20'(row_base_q) + 20'(pending_height_q));
			pending_height_q <= in_data.model_y_dim;
			model_width_q    <= in_data.model_x_dim;
		end
	end

	always_comb begin
		grid_x_prod = 18'(div_res.remainder) * 18'(cfg.cell_width);
		grid_y_prod = 17'(div_res.quotient) * 17'(cfg.cell_height);
		anim_x_prod = 17'(vz_q) * 17'(model_width_q);
		if (cfg.layout_mode) begin
			px_sum = 20'(vx_q) + 20'(grid_x_prod);
			py_sum = 20'(vy_q) + 20'(grid_y_prod);
		end else begin
			px_sum = 20'(vx_q) + 20'(anim_x_prod);
			py_sum = 20'(row_base_q) + 20'(vy_q);
		end
		idx_prod = 32'(py_q) * 32'(cfg.sheet_width);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			vx_q        <= '0;
			vy_q        <= '0;
			vz_q        <= '0;
			px_q        <= '0;
			py_q        <= '0;
		end else begin
			if (state_q == S_EMIT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (is_voxel) begin
						vx_q    <= in_data.vox_x;
						vy_q    <= in_data.vox_y;
						vz_q    <= in_data.vox_z;
						state_q <= S_DIV0;
					end
				end
				S_DIV0: state_q <= S_DIV1;
				S_DIV1: state_q <= S_MAP;
				S_MAP: begin
					px_q    <= sat16(px_sum);
					py_q    <= sat16(py_sum);
					state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						out_data_q.pixel_x     <= px_q;
						out_data_q.pixel_y     <= py_q;
						out_data_q.pixel_index <= 32'(px_q) + idx_prod;
						out_data_q.pixel_color <= pal_rdata;
						state_q                <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// The quotient and remainder must be settled by the time the coordinates are formed.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MAP) |-> div_res.done)
		else $error("slice divider not finished when coordinates are formed");

	// A new result appears only out of the emit step.
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == S_EMIT))
		else $error("result appeared outside the emit step");

	// A waiting result must never be overwritten by the next voxel.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT && out_valid_q && out_stall) |=> (state_q == S_EMIT))
		else $error("emit step left while the result register was still full");

	// A voxel acceptance always starts the divider.
	assert property (@(posedge clk) disable iff (!arst_n)
		is_voxel |=> (state_q == S_DIV0 && !div_res.done))
		else $error("voxel accepted without starting the divider");

endmodule

// ----- bench/sprite_map_tb_pkg.sv -----
// Request, register and layout codes shared by the sprite-sheet mapper bench files.
`timescale 1ns / 1ps

package sprite_map_tb_pkg;

	typedef enum logic [1:0] {
		REQ_VOXEL   = 2'd0,
		REQ_PALETTE = 2'd1,
		REQ_MODEL   = 2'd2,
		REQ_UNUSED  = 2'd3
	} req_e;

	typedef enum logic [2:0] {
		REG_LAYOUT_MODE   = 3'd0,
		REG_CELLS_PER_ROW = 3'd1,
		REG_CELL_WIDTH    = 3'd2,
		REG_CELL_HEIGHT   = 3'd3,
		REG_SHEET_WIDTH   = 3'd4
	} reg_e;

	typedef enum logic {
		LAYOUT_ANIMATED = 1'b0,
		LAYOUT_GRID     = 1'b1
	} layout_e;

endpackage

// ----- bench/sprite_map_checker.sv -----
// Pixel predictor and result comparator that watches the mapper's register port and channels.
`timescale 1ns / 1ps

module sprite_map_checker (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           psel,
	input  logic           penable,
	input  logic           pwrite,
	input  logic [4:0]     paddr,
	input  logic [31:0]    pwdata,
	input  logic           pready,
	input  logic           in_valid,
	input  logic           in_stall,
	input  vtsm_pkg::in_t  in_data,
	input  logic           out_valid,
	input  logic           out_stall,
	input  vtsm_pkg::out_t out_data,
	output int             mismatch_count,
	output int             pixels_pending
);

	import vtsm_pkg::*;
	import sprite_map_tb_pkg::*;

	logic [31:0] palette_copy [256];
	logic [15:0] row_base;
	logic [8:0]  pending_height;
	logic [8:0]  model_width;

	logic        layout_mode;
	logic [8:0]  cells_per_row;
	logic [8:0]  cell_width;
	logic [8:0]  cell_height;
	logic [15:0] sheet_width;

	out_t pixel_queue [$];

	function automatic logic [15:0] clamp16(input longint unsigned v);
		return (v > 64'd65535) ? 16'hFFFF : v[15:0];
	endfunction

	function automatic out_t map_voxel(input in_t b);
		out_t r;
		longint unsigned vx, vy, vz, cpr, px, py, entry;
		vx = 64'(b.vox_x);
		vy = 64'(b.vox_y);
		vz = 64'(b.vox_z);
		if (layout_mode == LAYOUT_GRID) begin
			// A zero cell count behaves as one cell per row.
			cpr = (cells_per_row == 9'd0) ? 64'd1 : 64'(cells_per_row);
			px = 64'(clamp16(vx + (vz % cpr) * 64'(cell_width)));
			py = 64'(clamp16(vy + (vz / cpr) * 64'(cell_height)));
		end else begin
			px = 64'(clamp16(vx + vz * 64'(model_width)));
			py = 64'(clamp16(64'(row_base) + vy));
		end
		entry = (64'(b.color_index) + 64'd254) % 64'd255;
		r.pixel_x = px[15:0];
		r.pixel_y = py[15:0];
		r.pixel_index = 32'(px + py * 64'(sheet_width));
		r.pixel_color = palette_copy[entry[7:0]];
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_t want;
		if (!arst_n) begin
			row_base = '0;
			pending_height = '0;
			model_width = 9'd1;
			layout_mode = LAYOUT_ANIMATED;
			cells_per_row = 9'd1;
			cell_width = 9'd1;
			cell_height = 9'd1;
			sheet_width = 16'd1;
			pixel_queue.delete();
			mismatch_count <= 0;
			pixels_pending <= 0;
		end else begin
			if (psel && penable && pwrite && pready) begin
				case (reg_e'(paddr[4:2]))
					REG_LAYOUT_MODE:   layout_mode = pwdata[0];
					REG_CELLS_PER_ROW: cells_per_row = pwdata[8:0];
					REG_CELL_WIDTH:    cell_width = pwdata[8:0];
					REG_CELL_HEIGHT:   cell_height = pwdata[8:0];
					REG_SHEET_WIDTH:   sheet_width = pwdata[15:0];
					default: ;
				endcase
			end

			// Results are retired before the new beat is predicted: a result can never
			// belong to a voxel accepted at the same edge.
			if (out_valid && !out_stall) begin
				if (pixel_queue.size() == 0) begin
					if (mismatch_count < 10) begin
						$display("unexpected pixel: x=%0d y=%0d index=%08h color=%08h",
							out_data.pixel_x, out_data.pixel_y, out_data.pixel_index,
							out_data.pixel_color);
					end
					mismatch_count <= mismatch_count + 1;
				end else begin
					want = pixel_queue.pop_front();
					if (out_data.pixel_x !== want.pixel_x || out_data.pixel_y !== want.pixel_y ||
						out_data.pixel_index !== want.pixel_index ||
						out_data.pixel_color !== want.pixel_color) begin
						if (mismatch_count < 10) begin
							$display("pixel mismatch: expected x=%0d y=%0d index=%08h color=%08h",
								want.pixel_x, want.pixel_y, want.pixel_index, want.pixel_color);
							$display("                got      x=%0d y=%0d index=%08h color=%08h",
								out_data.pixel_x, out_data.pixel_y, out_data.pixel_index,
								out_data.pixel_color);
						end
						mismatch_count <= mismatch_count + 1;
					end
				end
			end

			if (in_valid && !in_stall) begin
				case (in_data.req_type)
					REQ_PALETTE: palette_copy[in_data.palette_addr] = in_data.palette_word;
					REQ_MODEL: begin
						row_base = clamp16(64'(row_base) + 64'(pending_height));
						pending_height = in_data.model_y_dim;
						model_width = in_data.model_x_dim;
					end
					REQ_VOXEL: pixel_queue.push_back(map_voxel(in_data));
					default: ;
				endcase
			end
			pixels_pending <= pixel_queue.size();
		end
	end

endmodule

// ----- bench/testbench.sv -----
// Stimulus, reset, receiver stalls and verdict for the voxel to sprite-sheet mapper.
`timescale 1ns / 1ps

module testbench;

	import vtsm_pkg::*;
	import sprite_map_tb_pkg::*;

	localparam int IDLE_LIMIT    = 3000;
	localparam int SETTLE_CYCLES = 10;
	localparam int HOLD_CYCLES   = 400;
	localparam int RANDOM_PHASES = 5;
	localparam int PHASE_BEATS   = 240;
	localparam int MODEL_STACK   = 280;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [4:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        in_valid;
	logic        in_stall;
	in_t         in_data;
	logic        out_valid;
	logic        out_stall;
	out_t        out_data;

	int mismatch_count;
	int pixels_pending;
	int idle_cycles = 0;
	int burst_left = 0;
	bit entry_loaded [256];
	bit hold_request = 1'b0;
	bit hold_done = 1'b0;

	voxel_to_sprite_sheet_mapper_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data)
	);

	sprite_map_checker u_check (
		.clk            (clk),
		.arst_n         (arst_n),
		.psel           (psel),
		.penable        (penable),
		.pwrite         (pwrite),
		.paddr          (paddr),
		.pwdata         (pwdata),
		.pready         (pready),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.in_data        (in_data),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.out_data       (out_data),
		.mismatch_count (mismatch_count),
		.pixels_pending (pixels_pending)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Either end of the range or anything in between.
	function automatic int pick_span(input int lo, input int hi);
		int r;
		case ($urandom_range(0, 3))
			0: r = lo;
			1: r = hi;
			default: r = $urandom_range(lo, hi);
		endcase
		return r;
	endfunction

	function automatic in_t random_beat(input req_e req);
		in_t b;
		int ci;
		b.req_type = req;
		b.vox_x = 8'(pick_span(0, 255));
		b.vox_y = 8'(pick_span(0, 255));
		b.vox_z = 8'(pick_span(0, 255));
		b.color_index = 8'($urandom_range(0, 255));
		b.palette_addr = 8'($urandom_range(0, 255));
		b.palette_word = $urandom;
		b.model_x_dim = 9'(pick_span(1, 256));
		b.model_y_dim = 9'($urandom_range(1, 256));
		if (req == REQ_VOXEL) begin
			// Only colour indices whose palette entry has been loaded are used.
			do begin
				ci = $urandom_range(0, 255);
			end while (!entry_loaded[(ci + 254) % 255]);
			b.color_index = 8'(ci);
		end
		return b;
	endfunction

	function automatic in_t voxel_at(input int x, input int y, input int z, input int ci);
		in_t b;
		b = random_beat(REQ_VOXEL);
		b.vox_x = 8'(x);
		b.vox_y = 8'(y);
		b.vox_z = 8'(z);
		b.color_index = 8'(ci);
		return b;
	endfunction

	function automatic in_t model_of(input int xdim, input int ydim);
		in_t b;
		b = random_beat(REQ_MODEL);
		b.model_x_dim = 9'(xdim);
		b.model_y_dim = 9'(ydim);
		return b;
	endfunction

	function automatic in_t palette_entry(input int addr, input logic [31:0] word);
		in_t b;
		b = random_beat(REQ_PALETTE);
		b.palette_addr = 8'(addr);
		b.palette_word = word;
		return b;
	endfunction

	task automatic push_beat(input in_t b);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
			burst_left = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 16)
				: $urandom_range(40, 120);
		end
		in_data <= b;
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		if (b.req_type == REQ_PALETTE) begin
			entry_loaded[b.palette_addr] = 1'b1;
		end
		burst_left--;
	endtask

	task automatic apb_write(input reg_e idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	// Registers change only once the mapper has drained every pixel and settled.
	task automatic set_layout(input layout_e mode, input int cpr, input int cw, input int ch,
		input int sw);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pixels_pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		apb_write(REG_LAYOUT_MODE, 32'(mode));
		apb_write(REG_CELLS_PER_ROW, 32'(cpr));
		apb_write(REG_CELL_WIDTH, 32'(cw));
		apb_write(REG_CELL_HEIGHT, 32'(ch));
		apb_write(REG_SHEET_WIDTH, 32'(sw));
	endtask

	// Receiver: stall density changes from segment to segment, with one long hold-off.
	initial begin
		int seg_len;
		int pct;
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (hold_request && !hold_done) begin
				hold_done = 1'b1;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			seg_len = $urandom_range(16, 160);
			case ($urandom_range(0, 3))
				0: pct = 0;
				1: pct = 25;
				2: pct = 50;
				default: pct = 85;
			endcase
			repeat (seg_len) begin
				out_stall <= ($urandom_range(0, 99) < pct);
				@(posedge clk);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
				idle_cycles <= 0;
			end else if (idle_cycles >= IDLE_LIMIT) begin
				$display("Verification failed");
				$finish;
			end else begin
				idle_cycles <= idle_cycles + 1;
			end
		end
	end

	initial begin
		in_t b;
		int k;
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		in_valid <= 1'b0;
		in_data <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Animated layout: colour index wrap, widest models, zero and oversized dimensions.
		set_layout(LAYOUT_ANIMATED, 1, 1, 1, 65535);
		push_beat(palette_entry(254, 32'hFFFF_FFFF));
		push_beat(palette_entry(0, 32'h0000_0000));
		push_beat(palette_entry(127, 32'hA5C3_5A3C));
		push_beat(palette_entry(255, 32'h1234_5678));
		push_beat(voxel_at(0, 0, 0, 1));
		push_beat(model_of(256, 256));
		push_beat(voxel_at(255, 255, 255, 0));
		push_beat(voxel_at(0, 0, 255, 255));
		push_beat(model_of(1, 1));
		push_beat(voxel_at(255, 255, 255, 128));
		push_beat(random_beat(REQ_UNUSED));
		push_beat(model_of(0, 0));
		push_beat(voxel_at(17, 3, 200, 1));
		push_beat(model_of(511, 511));
		push_beat(voxel_at(255, 255, 255, 0));
		push_beat(model_of(256, 256));
		push_beat(voxel_at(128, 0, 1, 255));

		set_layout(LAYOUT_GRID, 256, 256, 256, 1);
		push_beat(voxel_at(255, 255, 255, 0));
		push_beat(voxel_at(0, 0, 128, 128));
		set_layout(LAYOUT_GRID, 1, 1, 1, 65535);
		push_beat(voxel_at(255, 255, 255, 1));
		// A zero cell count falls back to a single cell per row.
		set_layout(LAYOUT_GRID, 0, 256, 256, 300);
		push_beat(voxel_at(255, 255, 255, 255));
		push_beat(voxel_at(3, 9, 77, 128));

		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			set_layout(layout_e'($urandom_range(0, 1)), pick_span(1, 256), pick_span(1, 256),
				pick_span(1, 256), pick_span(1, 65535));
			if (phase == 0) begin
				for (int a = 0; a < 256; a++) begin
					push_beat(palette_entry(a, $urandom));
				end
			end
			if (phase == 1) begin
				hold_request = 1'b1;
			end
			for (int n = 0; n < PHASE_BEATS; n++) begin
				k = $urandom_range(0, 99);
				if (k < 62) begin
					b = random_beat(REQ_VOXEL);
				end else if (k < 82) begin
					b = random_beat(REQ_PALETTE);
				end else if (k < 95) begin
					b = random_beat(REQ_MODEL);
				end else if (k < 98) begin
					b = model_of($urandom_range(0, 1) ? 0 : $urandom_range(257, 511), 0);
				end else begin
					b = random_beat(REQ_UNUSED);
				end
				push_beat(b);
			end
		end

		// Stack tall models until the row base pins at the bottom of the sheet.
		set_layout(LAYOUT_ANIMATED, pick_span(1, 256), pick_span(1, 256), pick_span(1, 256),
			pick_span(1, 65535));
		for (int m = 0; m < MODEL_STACK; m++) begin
			push_beat(model_of(pick_span(1, 256), 256));
			if (m % 8 == 7) begin
				push_beat(random_beat(REQ_VOXEL));
			end
		end
		for (int n = 0; n < 10; n++) begin
			push_beat(random_beat(REQ_VOXEL));
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pixels_pending != 0) @(posedge clk);
		repeat (2 * SETTLE_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && pixels_pending == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
